// ===== design/wavhp_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared types and constants: parse phases, status codes and the result word.
// ----------------------------------------------------------------------------
package wavhp_pkg;

	// Little-endian magic words as they appear after four bytes are assembled.
	localparam logic [31:0] MagicRiff = 32'h4646_4952;
	localparam logic [31:0] MagicWave = 32'h4556_4157;
	localparam logic [31:0] MagicFmt  = 32'h2074_6D66;
	localparam logic [31:0] MagicFact = 32'h7463_6166;
	localparam logic [31:0] MagicData = 32'h6174_6164;

	// Largest fmt chunk body that is accepted.
	localparam logic [31:0] FmtBodyLen = 32'd16;

	// Reset value of the data length limit.
	localparam logic [31:0] MaxDataLenReset = 32'd65536;

	// Offset at which the chunk boundary limit sits below the RIFF size.
	localparam logic [31:0] RiffLimOffset = 32'd4;

	typedef enum logic [3:0] {
		PH_RIFF     = 4'd0,
		PH_SIZE     = 4'd1,
		PH_WAVE     = 4'd2,
		PH_CHUNK    = 4'd3,
		PH_FMTSIZE  = 4'd4,
		PH_FMT_A    = 4'd5,
		PH_RATE     = 4'd6,
		PH_AVG      = 4'd7,
		PH_FMT_B    = 4'd8,
		PH_DATASIZE = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_RIFF = 3'd1,
		ST_BAD_WAVE = 3'd2,
		ST_FMT_BIG  = 3'd3,
		ST_FACT     = 3'd4,
		ST_UNKNOWN  = 3'd5,
		ST_NO_DATA  = 3'd6
	} status_t;

	// One result word as it travels from the parser to the output buffer.
	typedef struct packed {
		status_t     status;
		logic [15:0] format_code;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [15:0] block_align;
		logic [15:0] bits_per_sample;
		logic [31:0] data_len;
		logic [31:0] data_offset;
		logic        truncated;
	} result_t;

endpackage

// ===== design/wavhp_parser.sv =====
// ----------------------------------------------------------------------------
// WAV header parser core
// Holds the parse state and consumes one byte per accepted word, producing
// at most one result word per file.
// ----------------------------------------------------------------------------
module wavhp_parser (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              data_byte,
	input  logic                    start_of_file,
	input  logic [31:0]             max_len,
	output logic                    res_valid,
	output wavhp_pkg::result_t      res
);

	wavhp_pkg::phase_t phase_q, phase_eff, phase_nxt;
	logic        fin_q, fin_eff;
	logic [31:0] off_q, off_eff, off_nxt;
	logic [31:0] shift_q, shift_eff, shift_nxt;
	logic [1:0]  bif_q, bif_eff, bif_nxt;
	logic [31:0] lim_q, lim_eff, lim_nxt;
	logic        big_q, big_eff, big_nxt;
	logic [63:0] fields_q, fields_eff, fields_nxt;
	logic [31:0] rate_q, rate_eff, rate_nxt;
	logic [31:0] w;
	logic        word_done;
	logic        room;
	logic        trunc;

	// A start flag makes the byte see a freshly cleared parser.
	assign phase_eff  = start_of_file ? wavhp_pkg::PH_RIFF : phase_q;
	assign fin_eff    = start_of_file ? 1'b0 : fin_q;
	assign off_eff    = start_of_file ? '0 : off_q;
	assign shift_eff  = start_of_file ? '0 : shift_q;
	assign bif_eff    = start_of_file ? '0 : bif_q;
	assign lim_eff    = start_of_file ? ('0 - wavhp_pkg::RiffLimOffset) : lim_q;
	assign big_eff    = start_of_file ? 1'b0 : big_q;
	assign fields_eff = start_of_file ? '0 : fields_q;
	assign rate_eff   = start_of_file ? '0 : rate_q;

	// Byte assembly: new bytes enter at the top of the word.
	assign off_nxt   = off_eff + 32'd1;
	assign shift_nxt = {data_byte, shift_eff[31:8]};
	assign bif_nxt   = bif_eff + 2'd1;
	assign word_done = (bif_nxt == 2'd0);
	assign w         = shift_nxt;

	// A new chunk may start only while the offset is below the RIFF limit.
	assign room  = (off_nxt < lim_eff);
	assign trunc = (w > max_len);

	// Next state of the phase and of the captured header fields.
	always_comb begin
		phase_nxt  = phase_eff;
		lim_nxt    = lim_eff;
		big_nxt    = big_eff;
		fields_nxt = fields_eff;
		rate_nxt   = rate_eff;
		if (word_done) begin
			case (phase_eff)
				wavhp_pkg::PH_RIFF: phase_nxt = wavhp_pkg::PH_SIZE;
				wavhp_pkg::PH_SIZE: begin
					lim_nxt   = w - wavhp_pkg::RiffLimOffset;
					phase_nxt = wavhp_pkg::PH_WAVE;
				end
				wavhp_pkg::PH_WAVE: phase_nxt = wavhp_pkg::PH_CHUNK;
				wavhp_pkg::PH_CHUNK: begin
					if (w == wavhp_pkg::MagicFmt) begin
						phase_nxt = wavhp_pkg::PH_FMTSIZE;
					end else if (w == wavhp_pkg::MagicData) begin
						phase_nxt = wavhp_pkg::PH_DATASIZE;
					end
				end
				wavhp_pkg::PH_FMTSIZE: begin
					big_nxt   = (w > wavhp_pkg::FmtBodyLen);
					phase_nxt = wavhp_pkg::PH_FMT_A;
				end
				wavhp_pkg::PH_FMT_A: begin
					fields_nxt[31:0] = w;
					phase_nxt        = wavhp_pkg::PH_RATE;
				end
				wavhp_pkg::PH_RATE: begin
					rate_nxt  = w;
					phase_nxt = wavhp_pkg::PH_AVG;
				end
				wavhp_pkg::PH_AVG: phase_nxt = wavhp_pkg::PH_FMT_B;
				wavhp_pkg::PH_FMT_B: begin
					fields_nxt[63:32] = w;
					phase_nxt         = wavhp_pkg::PH_CHUNK;
				end
				default: phase_nxt = phase_eff;
			endcase
		end
	end

	// Result word: an error clears every field but the status.
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		res.status = wavhp_pkg::ST_OK;
		if (accept && !fin_eff && word_done) begin
			case (phase_eff)
				wavhp_pkg::PH_RIFF: begin
					if (w != wavhp_pkg::MagicRiff) begin
						res_valid  = 1'b1;
						res.status = wavhp_pkg::ST_BAD_RIFF;
					end
				end
				wavhp_pkg::PH_WAVE: begin
					if (w != wavhp_pkg::MagicWave) begin
						res_valid  = 1'b1;
						res.status = wavhp_pkg::ST_BAD_WAVE;
					end else if (!room) begin
						res_valid  = 1'b1;
						res.status = wavhp_pkg::ST_NO_DATA;
					end
				end
				wavhp_pkg::PH_CHUNK: begin
					if (w == wavhp_pkg::MagicFact) begin
						res_valid  = 1'b1;
						res.status = wavhp_pkg::ST_FACT;
					end else if (w != wavhp_pkg::MagicFmt && w != wavhp_pkg::MagicData) begin
						res_valid  = 1'b1;
						res.status = wavhp_pkg::ST_UNKNOWN;
					end
				end
				wavhp_pkg::PH_FMT_B: begin
					if (big_eff) begin
						res_valid  = 1'b1;
						res.status = wavhp_pkg::ST_FMT_BIG;
					end else if (!room) begin
						res_valid  = 1'b1;
						res.status = wavhp_pkg::ST_NO_DATA;
					end
				end
				wavhp_pkg::PH_DATASIZE: begin
					res_valid           = 1'b1;
					res.status          = wavhp_pkg::ST_OK;
					res.format_code     = fields_eff[15:0];
					res.channel_count   = fields_eff[31:16];
					res.sample_rate     = rate_eff;
					res.block_align     = fields_eff[47:32];
					res.bits_per_sample = fields_eff[63:48];
					res.data_len        = trunc ? max_len : w;
					res.data_offset     = off_nxt;
					res.truncated       = trunc;
				end
				wavhp_pkg::PH_SIZE, wavhp_pkg::PH_FMTSIZE, wavhp_pkg::PH_FMT_A,
				wavhp_pkg::PH_RATE, wavhp_pkg::PH_AVG: begin
					res_valid = 1'b0;
				end
				default: begin
					res_valid  = 1'b1;
					res.status = wavhp_pkg::ST_UNKNOWN;
				end
			endcase
		end
	end

	// Parse state: a finished file ignores bytes until the next start flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wavhp_pkg::PH_RIFF;
			fin_q    <= 1'b0;
			off_q    <= '0;
			shift_q  <= '0;
			bif_q    <= '0;
			lim_q    <= '0 - wavhp_pkg::RiffLimOffset;
			big_q    <= 1'b0;
			fields_q <= '0;
			rate_q   <= '0;
		end else if (accept && !fin_eff) begin
			phase_q  <= phase_nxt;
			fin_q    <= res_valid;
			off_q    <= off_nxt;
			shift_q  <= shift_nxt;
			bif_q    <= bif_nxt;
			lim_q    <= lim_nxt;
			big_q    <= big_nxt;
			fields_q <= fields_nxt;
			rate_q   <= rate_nxt;
		end
	end

endmodule

// ===== design/wavhp_out_buf.sv =====
// ----------------------------------------------------------------------------
// WAV header parser output buffer
// Output register backed by a skid register, so the parser keeps taking
// bytes while a result waits for the receiver.
// ----------------------------------------------------------------------------
module wavhp_out_buf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    res_valid,
	input  wavhp_pkg::result_t      res,
	input  logic                    out_stall,
	output logic                    out_valid,
	output wavhp_pkg::result_t      out_res,
	output logic                    full
);

	logic               main_valid_q;
	wavhp_pkg::result_t main_q;
	logic               skid_valid_q;
	wavhp_pkg::result_t skid_q;
	logic               take;

	assign take      = main_valid_q && !out_stall;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;
	assign full      = skid_valid_q;

	// Valid flags of the two slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (!main_valid_q || take) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			main_valid_q <= 1'b0;
		end
	end

	// Payload of the two slots.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				main_q <= skid_q;
			end
		end else if (res_valid) begin
			if (!main_valid_q || take) begin
				main_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

endmodule

// ===== design/wav_header_parser.sv =====
// ----------------------------------------------------------------------------
// WAV header parser
// Parses the RIFF/WAVE header of a byte stream and reports the format
// fields, the data length and the offset of the first sample.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one file byte per word in
// data_byte; start_of_file marks the first byte of a new file and restarts
// the parser. The output channel (out_valid, out_stall) carries one result
// word per file, sent on the data size word or on the first error. Bytes
// after the result are dropped until the next start_of_file.
// A byte is taken every cycle while in_stall is low. The result that a byte
// completes is registered in the output buffer; the path is one level of
// compare and offset add between the parse state registers and that buffer.
// When the receiver stalls, the result is held and one more result can be
// parked in a skid register; in_stall rises only while that skid is full.
// cfg_we with cfg_wdata writes max_data_len, which clamps data_len.
// After reset the parser waits for a RIFF magic, no result is pending, and
// max_data_len is 65536.
// ----------------------------------------------------------------------------
module wav_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] format_code,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [15:0] block_align,
	output logic [15:0] bits_per_sample,
	output logic [31:0] data_len,
	output logic [31:0] data_offset,
	output logic        truncated,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	logic [31:0]        max_data_len_q;
	logic               accept;
	logic               res_valid;
	wavhp_pkg::result_t res;
	wavhp_pkg::result_t out_res;
	logic               full;

	// Data length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_data_len_q <= wavhp_pkg::MaxDataLenReset;
		end else if (cfg_we) begin
			max_data_len_q <= cfg_wdata;
		end
	end

	assign in_stall  = full;
	assign accept    = in_valid && !in_stall;

	wavhp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.max_len       (max_data_len_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	wavhp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.full      (full)
	);

	// Result fields on the output ports.
	assign status          = out_res.status;
	assign format_code     = out_res.format_code;
	assign channel_count   = out_res.channel_count;
	assign sample_rate     = out_res.sample_rate;
	assign block_align     = out_res.block_align;
	assign bits_per_sample = out_res.bits_per_sample;
	assign data_len        = out_res.data_len;
	assign data_offset     = out_res.data_offset;
	assign truncated       = out_res.truncated;

	// The skid register is only used behind a full output register.
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output register is empty");

	// An error result carries nothing but its status.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != wavhp_pkg::ST_OK) |->
		(format_code == 16'd0 && data_len == 32'd0 && data_offset == 32'd0
		 && truncated == 1'b0))
		else $error("error result with nonzero fields");

	// A clamped length never exceeds the limit in force.
	a_trunc_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && truncated && $stable(max_data_len_q)) |->
		(data_len <= max_data_len_q))
		else $error("truncated length above limit");

endmodule
